[sv/pot_pkg.sv]
// Shared definitions for the partitioned object table.
// Action and status codes, the default depth and the request/response structs.
// Used by pot_core and partitioned_object_table; depends on nothing.
package pot_pkg;

    localparam int POT_DEPTH = 64;

    localparam int ACT_W  = 3;
    localparam int ID_W   = 16;
    localparam int BOX_W  = 16;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int REM_W  = 2;
    localparam int CNT_W  = 7;

    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_FIXED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_MOV   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_FIXED = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DEL_MOV   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DEL_ANY   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_FIX_AFTER = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  object_id;
        logic [BOX_W-1:0] box_handle;
        logic [IDX_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [BOX_W-1:0]  read_box;
        logic [ID_W-1:0]   read_id;
        logic [CNT_W-1:0]  movable_count;
        logic [CNT_W-1:0]  fixed_count;
        logic [REM_W-1:0]  removed_count;
        logic [STAT_W-1:0] status;
    } t_rsp;

endpackage

[sv/pot_core.sv]
// Sequencer and entry memory of the partitioned object table.
// One read and one write port on the entry memory are reused for every scan and shift.
// Depends on pot_pkg.
module pot_core
    import pot_pkg::*;
#(
    parameter int TABLE_DEPTH = POT_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_vld,
    input  t_req i_req,
    output logic o_req_rdy,
    output logic o_rsp_vld,
    output t_rsp o_rsp,
    input  logic i_rsp_rdy
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_FSCAN = 4'd2;
    localparam logic [3:0] S_SHIFT = 4'd3;
    localparam logic [3:0] S_MSCAN = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_MWR   = 4'd6;
    localparam logic [3:0] S_RDATA = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [ID_W+BOX_W-1:0] r_mem [TABLE_DEPTH];
    logic [ID_W+BOX_W-1:0] r_rdata;

    logic [3:0]        r_state,   n_state;
    logic [CW-1:0]     r_fixed,   n_fixed;
    logic [CW-1:0]     r_movable, n_movable;
    logic [CW-1:0]     r_ptr,     n_ptr;
    logic [AW-1:0]     r_tag,     n_tag;
    logic              r_vld,     n_vld;
    t_req              r_req,     n_req;
    logic [STAT_W-1:0] r_status,  n_status;
    logic [REM_W-1:0]  r_removed, n_removed;
    logic [ID_W-1:0]   r_rid,     n_rid;
    logic [BOX_W-1:0]  r_rbox,    n_rbox;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [ID_W+BOX_W-1:0] mem_wdata;
    logic [CW-1:0]         used;
    logic                  hit;
    logic                  is_del;

    assign used   = r_fixed + r_movable;
    assign hit    = r_vld && (r_rdata[ID_W-1:0] == r_req.object_id);
    assign is_del = (r_req.action == ACT_DEL_FIXED) || (r_req.action == ACT_DEL_MOV) ||
                    (r_req.action == ACT_DEL_ANY);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state   = r_state;
        n_fixed   = r_fixed;
        n_movable = r_movable;
        n_ptr     = r_ptr;
        n_tag     = r_tag;
        n_vld     = r_vld;
        n_req     = r_req;
        n_status  = r_status;
        n_removed = r_removed;
        n_rid     = r_rid;
        n_rbox    = r_rbox;
        mem_we    = 1'b0;
        mem_waddr = r_tag;
        mem_wdata = r_rdata;
        mem_raddr = r_ptr[AW-1:0];
        o_rsp_vld = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    n_req     = i_req;
                    n_status  = ST_OK;
                    n_removed = '0;
                    n_rid     = '0;
                    n_rbox    = '0;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (r_req.action)
                    ACT_CLEAR: begin
                        n_fixed   = '0;
                        n_movable = '0;
                    end
                    ACT_ADD_FIXED: begin
                        if (r_movable != '0) begin
                            n_status = ST_FIX_AFTER;
                        end else if (used >= DEPTH_C) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = used[AW-1:0];
                            mem_wdata = {r_req.box_handle, r_req.object_id};
                            n_fixed   = r_fixed + 1'b1;
                        end
                    end
                    ACT_ADD_MOV: begin
                        if (used >= DEPTH_C) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = used[AW-1:0];
                            mem_wdata = {r_req.box_handle, r_req.object_id};
                            n_movable = r_movable + 1'b1;
                        end
                    end
                    ACT_DEL_FIXED, ACT_DEL_ANY: begin
                        n_ptr   = '0;
                        n_vld   = 1'b0;
                        n_state = S_FSCAN;
                    end
                    ACT_DEL_MOV: begin
                        n_ptr   = r_fixed;
                        n_vld   = 1'b0;
                        n_state = S_MSCAN;
                    end
                    ACT_READ: begin
                        if ((XW'(r_req.entry_index) < XW'(used)) &&
                            (XW'(r_req.entry_index) < XW'(DEPTH_C))) begin
                            mem_raddr = AW'(r_req.entry_index);
                            n_state   = S_RDATA;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_FSCAN: begin
                // compare the beat read last cycle while the next address goes out
                if (hit) begin
                    n_ptr   = CW'(r_tag) + 1'b1;
                    n_vld   = 1'b0;
                    n_state = S_SHIFT;
                end else if (r_ptr < r_fixed) begin
                    n_ptr = r_ptr + 1'b1;
                    n_vld = 1'b1;
                    n_tag = r_ptr[AW-1:0];
                end else begin
                    n_vld = 1'b0;
                    if (!r_vld) begin
                        if (r_req.action == ACT_DEL_ANY) begin
                            n_ptr   = r_fixed;
                            n_state = S_MSCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // move each later entry down one place
                if (r_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_tag - 1'b1;
                end
                if (r_ptr < used) begin
                    n_ptr = r_ptr + 1'b1;
                    n_vld = 1'b1;
                    n_tag = r_ptr[AW-1:0];
                end else begin
                    n_vld = 1'b0;
                    if (!r_vld) begin
                        n_fixed   = r_fixed - 1'b1;
                        n_removed = r_removed + 1'b1;
                        if (r_req.action == ACT_DEL_ANY) begin
                            n_ptr   = r_fixed - 1'b1;
                            n_state = S_MSCAN;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_MSCAN: begin
                if (hit) begin
                    n_vld   = 1'b0;
                    n_state = S_MRD;
                end else if (r_ptr < used) begin
                    n_ptr = r_ptr + 1'b1;
                    n_vld = 1'b1;
                    n_tag = r_ptr[AW-1:0];
                end else begin
                    n_vld = 1'b0;
                    if (!r_vld) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MRD: begin
                mem_raddr = AW'(used - 1'b1);
                n_state   = S_MWR;
            end
            S_MWR: begin
                // fill the hole with the last entry
                mem_we    = 1'b1;
                mem_waddr = r_tag;
                n_movable = r_movable - 1'b1;
                n_removed = r_removed + 1'b1;
                n_state   = S_DONE;
            end
            S_RDATA: begin
                n_rid   = r_rdata[ID_W-1:0];
                n_rbox  = r_rdata[ID_W+BOX_W-1:ID_W];
                n_state = S_DONE;
            end
            S_DONE: begin
                o_rsp_vld = 1'b1;
                if (i_rsp_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fixed   <= '0;
            r_movable <= '0;
            r_vld     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fixed   <= n_fixed;
            r_movable <= n_movable;
            r_vld     <= n_vld;
        end
        r_ptr     <= n_ptr;
        r_tag     <= n_tag;
        r_req     <= n_req;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_rid     <= n_rid;
        r_rbox    <= n_rbox;
    end

    assign o_req_rdy = (r_state == S_IDLE);

    always_comb begin
        o_rsp.status        = (is_del && (r_removed == '0)) ? ST_NOT_FOUND : r_status;
        o_rsp.removed_count = r_removed;
        o_rsp.fixed_count   = CNT_W'(r_fixed);
        o_rsp.movable_count = CNT_W'(r_movable);
        o_rsp.read_id       = r_rid;
        o_rsp.read_box      = r_rbox;
    end

endmodule

[sv/partitioned_object_table.sv]
// Top level of the partitioned object table: stream ports and the result register.
// Depends on pot_pkg and pot_core.
//
// One beat in gives one beat out. Add, clear and unused actions are settled in the
// dispatch state; a read also passes through the read data state. A delete runs
// through the single read port of the entry memory one address per cycle: a fixed
// delete scans up to the matching entry and then shifts every later entry down; a
// movable delete scans the movable entries and fills the hole with the last one;
// delete any does both. The input is ready only while no action is in progress. Reset
// clears the counts; entry contents are never cleared and are only read once written.
module partitioned_object_table
    import pot_pkg::*;
#(
    parameter int TABLE_DEPTH = POT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // object_id, box_handle, entry_index, zero pad
    input  logic [2:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // status, removed_count, fixed_count,
                                       // movable_count, read_id, read_box, zero pad
);

    t_req req;
    t_rsp rsp;
    t_rsp r_out;
    logic rsp_vld;
    logic rsp_rdy;
    logic r_out_vld;

    always_comb begin
        req.action      = s_axis_tuser;
        req.object_id   = s_axis_tdata[15:0];
        req.box_handle  = s_axis_tdata[31:16];
        req.entry_index = s_axis_tdata[37:32];
    end

    // take a new result when the register is empty or drains this cycle
    assign rsp_rdy = !r_out_vld || m_axis_tready;

    pot_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_vld(s_axis_tvalid),
        .i_req    (req),
        .o_req_rdy(s_axis_tready),
        .o_rsp_vld(rsp_vld),
        .o_rsp    (rsp),
        .i_rsp_rdy(rsp_rdy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (rsp_rdy) begin
            r_out_vld <= rsp_vld;
        end
        if (rsp_rdy && rsp_vld) begin
            r_out <= rsp;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out};

endmodule
